// ===== hdl/tqm_pkg.sv =====
// shared constants for the triangle quality metrics block
`default_nettype none
package tqm_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_THRESHOLD = 1'b1;

  // dimension mode codes
  localparam int unsigned DIM_W = 2;
  localparam logic [DIM_W-1:0] DIM_2D = 2'd2;
  localparam logic [DIM_W-1:0] DIM_3D = 2'd3;

  // result and quotient width
  localparam int unsigned OUT_W = 32;
  localparam int unsigned QUO_W = 32;

  // multiplier digit width
  localparam int unsigned MUL_CHUNK = 16;

  // cross product components at or above this bit are prescaled
  localparam int unsigned CROSS_LIM = 62;
  localparam int unsigned CROSS_SHIFT = 4;

  // gamma numerator scale: q16 fraction times two for the doubled area
  localparam int unsigned SHAPE_SHIFT = 17;

endpackage
`default_nettype wire

// ===== hdl/tqm_sqrt_cell.sv =====
// one restoring square root step: two radicand bits in, one root bit out
`default_nettype none
module tqm_sqrt_cell #(
  parameter int unsigned N = 4
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [N-1:0]   rad_i,
  input  logic [N/2:0]   rem_i,
  input  logic [N/2-1:0] root_i,
  output logic [N-1:0]   rad_o,
  output logic [N/2:0]   rem_o,
  output logic [N/2-1:0] root_o
);
  localparam int unsigned RW = N / 2;

  logic [RW+2:0] cur, trial, diff;
  logic          ge;
  logic [N-1:0]  rad_d, rad_q;
  logic [RW:0]   rem_d, rem_q;
  logic [RW-1:0] root_d, root_q;

  always_comb begin
    cur    = {rem_i, rad_i[N-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = (cur >= trial);
    diff   = cur - trial;
    rem_d  = ge ? diff[RW:0] : cur[RW:0];
    root_d = {root_i[RW-2:0], ge};
    rad_d  = rad_i << 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

// ===== hdl/tqm_mul_cell.sv =====
// one multiplier step: operand times one digit of the other, accumulated
`default_nettype none
module tqm_mul_cell #(
  parameter int unsigned AW  = 16,
  parameter int unsigned BPW = 16,
  parameter int unsigned PW  = 32,
  parameter int unsigned IDX = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [AW-1:0]  a_i,
  input  logic [BPW-1:0] b_i,
  input  logic [PW-1:0]  acc_i,
  output logic [AW-1:0]  a_o,
  output logic [BPW-1:0] b_o,
  output logic [PW-1:0]  acc_o
);
  localparam int unsigned CH = tqm_pkg::MUL_CHUNK;

  logic [CH-1:0]    digit;
  logic [AW+CH-1:0] pp;
  logic [PW-1:0]    acc_d, acc_q;
  logic [AW-1:0]    a_q;
  logic [BPW-1:0]   b_q;

  always_comb begin
    digit = b_i[IDX*CH +: CH];
    pp    = (AW+CH)'(a_i) * (AW+CH)'(digit);
    acc_d = acc_i + (PW'(pp) << (IDX*CH));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= acc_d;
    end
  end

  assign a_o   = a_q;
  assign b_o   = b_q;
  assign acc_o = acc_q;
endmodule
`default_nettype wire

// ===== hdl/tqm_div_cell.sv =====
// one restoring division step producing one quotient bit
`default_nettype none
module tqm_div_cell #(
  parameter int unsigned DW = 8
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [DW-1:0]              d_i,
  input  logic [DW-1:0]              r_i,
  input  logic [tqm_pkg::QUO_W-1:0]  nlow_i,
  input  logic [tqm_pkg::QUO_W-1:0]  q_i,
  output logic [DW-1:0]              d_o,
  output logic [DW-1:0]              r_o,
  output logic [tqm_pkg::QUO_W-1:0]  nlow_o,
  output logic [tqm_pkg::QUO_W-1:0]  q_o
);
  localparam int unsigned QW = tqm_pkg::QUO_W;

  logic [DW:0]   cur, diff;
  logic          ge;
  logic [DW-1:0] r_d, r_q, d_q;
  logic [QW-1:0] q_d, q_q, nlow_d, nlow_q;

  always_comb begin
    cur    = {r_i, nlow_i[QW-1]};
    ge     = (cur >= {1'b0, d_i});
    diff   = cur - {1'b0, d_i};
    r_d    = ge ? diff[DW-1:0] : cur[DW-1:0];
    q_d    = {q_i[QW-2:0], ge};
    nlow_d = nlow_i << 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= d_i;
      r_q    <= r_d;
      q_q    <= q_d;
      nlow_q <= nlow_d;
    end
  end

  assign d_o    = d_q;
  assign r_o    = r_q;
  assign nlow_o = nlow_q;
  assign q_o    = q_q;
endmodule
`default_nettype wire

// ===== hdl/tqm_delay.sv =====
// register line that keeps side data in step with the pipeline
`default_nettype none
module tqm_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);
  if (DEPTH == 0) begin : g_none
    assign q_o = d_i;
  end else begin : g_line
    logic [WIDTH-1:0] sr_q [DEPTH];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_q[0] <= d_i;
        for (int k = 1; k < DEPTH; k++) begin
          sr_q[k] <= sr_q[k-1];
        end
      end
    end
    assign q_o = sr_q[DEPTH-1];
  end
endmodule
`default_nettype wire

// ===== hdl/triangle_quality_metrics.sv =====
// top level of the triangle quality metrics pipeline
`default_nettype none
// Takes one triangle (three vertices, signed fixed point) per cycle and returns
// circumradius, inradius and the gamma shape ratio, plus a degenerate flag.
// The datapath is one stall-together pipeline of step cells: square
// root cells (one root bit each), multiplier cells (one 16-bit digit each) and
// divider cells (one quotient bit each). Throughput is one item per clock while
// the result is taken or the output register is empty. The area square root
// chain has RA = 2*COORD_WIDTH+3 (capped at 63) cells, and NCH = ceil(RA-1 / 16)
// multiplier cells square the cross product. When the result is not taken the
// whole pipeline holds. Configuration writes are taken in any cycle and should
// only be made while no item is in flight.
module triangle_quality_metrics #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tqm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tqm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // triangle in
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]       vertex_a_x_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex_a_y_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex_a_z_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex_b_x_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex_b_y_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex_b_z_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex_c_x_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex_c_y_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex_c_z_i,
  // metrics out
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tqm_pkg::OUT_W-1:0]           outer_radius_o,
  output logic [tqm_pkg::OUT_W-1:0]           inner_radius_o,
  output logic [tqm_pkg::OUT_W-1:0]           shape_ratio_o,
  output logic                                degenerate_o
);
  // ---------------------------------------------------------------- widths
  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned CH   = tqm_pkg::MUL_CHUNK;
  localparam int unsigned QW   = tqm_pkg::QUO_W;
  localparam int unsigned OW   = tqm_pkg::OUT_W;
  localparam int unsigned DFW  = W + 1;          // coordinate difference
  localparam int unsigned SQW  = 2 * W + 2;      // squared edge length
  localparam int unsigned SSW  = 2 * W + 4;      // sum of squared edges
  localparam int unsigned CRW  = 2 * W + 3;      // signed cross component
  localparam int unsigned XW   = 2 * W + 2;      // cross component magnitude
  localparam bit          HAS_SH = (XW > tqm_pkg::CROSS_LIM);
  localparam int unsigned CSW  = HAS_SH ? tqm_pkg::CROSS_LIM : XW;
  localparam int unsigned SHB  = HAS_SH ? tqm_pkg::CROSS_SHIFT : 0;
  localparam int unsigned NCH  = (CSW + CH - 1) / CH;
  localparam int unsigned CBP  = NCH * CH;
  localparam int unsigned PSW  = 2 * CSW;
  localparam int unsigned ARW  = 2 * CSW + 2;    // area root radicand
  localparam int unsigned RA   = ARW / 2;
  localparam int unsigned TAW  = RA + SHB;       // twice the area
  localparam int unsigned LW   = W + 1;          // edge length
  localparam int unsigned RE   = LW;
  localparam int unsigned PRW  = LW + 2;         // perimeter
  localparam int unsigned LABW = 2 * LW;
  localparam int unsigned NUMW = 3 * LW;
  localparam int unsigned NCHL = (LW + CH - 1) / CH;
  localparam int unsigned LBP  = NCHL * CH;
  localparam int unsigned DE   = NCH + RA - RE - NCHL;
  localparam int unsigned DSUM = NCH + 1 + RA;
  localparam int unsigned THW  = 32 + FRAC_BITS + 1;
  localparam int unsigned CMW  = (THW > TAW) ? THW : TAW;
  // divider operand widths: outer, inner, shape
  localparam int unsigned ONW  = NUMW;
  localparam int unsigned ODW  = TAW + 1;
  localparam int unsigned INW  = TAW;
  localparam int unsigned IDW  = PRW;
  localparam int unsigned SNW  = SSW + tqm_pkg::SHAPE_SHIFT;
  localparam int unsigned SDW  = TAW + 2;
  localparam int unsigned OXW  = ((ONW > ODW) ? ONW : ODW) + QW;
  localparam int unsigned IXW  = ((INW > IDW) ? INW : IDW) + QW;
  localparam int unsigned SXW  = ((SNW > SDW) ? SNW : SDW) + QW;
  // total pipeline depth
  localparam int unsigned TA   = 5 + NCH + RA + 2;
  localparam int unsigned L    = TA + 3 + QW;
  localparam int unsigned FLW  = 5;

  // --------------------------------------------------- configuration regs
  logic [tqm_pkg::DIM_W-1:0] dim_q;
  logic [31:0]               thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= tqm_pkg::DIM_3D;
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tqm_pkg::REG_DIMENSION_MODE: dim_q <= cfg_data_i[tqm_pkg::DIM_W-1:0];
        tqm_pkg::REG_AREA_THRESHOLD: thr_q <= cfg_data_i[31:0];
      endcase
    end
  end

  // ------------------------------------------------------ pipeline control
  // every stage moves together; the last stage is the output register
  logic [L-1:0] vld_q;
  logic         en;

  assign en          = !vld_q[L-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  // ------------------------------------------- stage 1: capture, 2d masking
  logic signed [W-1:0] p_d [3][3];
  logic signed [W-1:0] p_q [3][3];

  always_comb begin
    p_d[0][0] = vertex_a_x_i;
    p_d[0][1] = vertex_a_y_i;
    p_d[0][2] = vertex_a_z_i;
    p_d[1][0] = vertex_b_x_i;
    p_d[1][1] = vertex_b_y_i;
    p_d[1][2] = vertex_b_z_i;
    p_d[2][0] = vertex_c_x_i;
    p_d[2][1] = vertex_c_y_i;
    p_d[2][2] = vertex_c_z_i;
    // planar mode drops z entirely
    if (dim_q == tqm_pkg::DIM_2D) begin
      for (int i = 0; i < 3; i++) begin
        p_d[i][2] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p_d;
    end
  end

  // ------------------------------------------------ stage 2: edge vectors
  // u = B-A (edge a), v = C-A (edge c), w = C-B (edge b)
  logic signed [DFW-1:0] u_q [3];
  logic signed [DFW-1:0] v_q [3];
  logic signed [DFW-1:0] w_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= DFW'(p_q[1][k]) - DFW'(p_q[0][k]);
        v_q[k] <= DFW'(p_q[2][k]) - DFW'(p_q[0][k]);
        w_q[k] <= DFW'(p_q[2][k]) - DFW'(p_q[1][k]);
      end
    end
  end

  // ----------------------------------- stage 3: squares and cross products
  logic [DFW-1:0]        mag_d [3][3];
  logic [SQW-1:0]        sq_q  [3][3];
  logic signed [XW-1:0]  xp_d  [6];
  logic signed [XW-1:0]  xp_q  [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_d[0][k] = u_q[k][DFW-1] ? DFW'(-u_q[k]) : DFW'(u_q[k]);
      mag_d[1][k] = w_q[k][DFW-1] ? DFW'(-w_q[k]) : DFW'(w_q[k]);
      mag_d[2][k] = v_q[k][DFW-1] ? DFW'(-v_q[k]) : DFW'(v_q[k]);
    end
    xp_d[0] = XW'(u_q[1]) * XW'(v_q[2]);
    xp_d[1] = XW'(u_q[2]) * XW'(v_q[1]);
    xp_d[2] = XW'(u_q[2]) * XW'(v_q[0]);
    xp_d[3] = XW'(u_q[0]) * XW'(v_q[2]);
    xp_d[4] = XW'(u_q[0]) * XW'(v_q[1]);
    xp_d[5] = XW'(u_q[1]) * XW'(v_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          sq_q[j][k] <= SQW'(mag_d[j][k]) * SQW'(mag_d[j][k]);
        end
      end
      xp_q <= xp_d;
    end
  end

  // ------------------------ stage 4: squared lengths, cross magnitudes
  logic [SQW-1:0]        len2_q [3];
  logic [SSW-1:0]        sumsq_q;
  logic signed [CRW-1:0] cd     [3];
  logic [XW-1:0]         cr_d   [3];
  logic [XW-1:0]         cr_q   [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cd[k]   = CRW'(xp_q[2*k]) - CRW'(xp_q[2*k+1]);
      cr_d[k] = cd[k][CRW-1] ? XW'(-cd[k]) : XW'(cd[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        len2_q[j] <= sq_q[j][0] + sq_q[j][1] + sq_q[j][2];
      end
      sumsq_q <= SSW'(sq_q[0][0]) + SSW'(sq_q[0][1]) + SSW'(sq_q[0][2])
               + SSW'(sq_q[1][0]) + SSW'(sq_q[1][1]) + SSW'(sq_q[1][2])
               + SSW'(sq_q[2][0]) + SSW'(sq_q[2][1]) + SSW'(sq_q[2][2]);
      cr_q <= cr_d;
    end
  end

  // ------------------------------- stage 5: prescale of huge cross terms
  logic [CSW-1:0] crs_d [3];
  logic [CSW-1:0] crs_q [3];
  logic           sh_d, sh_q;
  logic [SQW-1:0] len2p_q [3];
  logic [SSW-1:0] sumsq5_q;

  if (HAS_SH) begin : g_prescale
    always_comb begin
      sh_d = 1'b0;
      for (int k = 0; k < 3; k++) begin
        sh_d = sh_d | (|cr_q[k][XW-1:tqm_pkg::CROSS_LIM]);
      end
      for (int k = 0; k < 3; k++) begin
        crs_d[k] = sh_d ? CSW'(cr_q[k] >> SHB) : CSW'(cr_q[k]);
      end
    end
  end else begin : g_noscale
    // components always stay below the prescale limit at this width
    assign sh_d = 1'b0;
    for (genvar k = 0; k < 3; k++) begin : g_k
      assign crs_d[k] = cr_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crs_q    <= crs_d;
      sh_q     <= sh_d;
      len2p_q  <= len2_q;
      sumsq5_q <= sumsq_q;
    end
  end

  // --------------------------------------------- area path: cross squares
  logic [CSW-1:0] ma   [3][NCH+1];
  logic [CBP-1:0] mb   [3][NCH+1];
  logic [PSW-1:0] macc [3][NCH+1];

  for (genvar j = 0; j < 3; j++) begin : g_xsq
    assign ma[j][0]   = crs_q[j];
    assign mb[j][0]   = CBP'(crs_q[j]);
    assign macc[j][0] = '0;
    for (genvar i = 0; i < NCH; i++) begin : g_cell
      tqm_mul_cell #(
        .AW (CSW),
        .BPW(CBP),
        .PW (PSW),
        .IDX(i)
      ) u_cell (
        .clk_i(clk_i),
        .en_i (en),
        .a_i  (ma[j][i]),
        .b_i  (mb[j][i]),
        .acc_i(macc[j][i]),
        .a_o  (ma[j][i+1]),
        .b_o  (mb[j][i+1]),
        .acc_o(macc[j][i+1])
      );
    end
  end

  // squared cross magnitude is (2 * area)^2
  logic [ARW-1:0] qsum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      qsum_q <= ARW'(macc[0][NCH]) + ARW'(macc[1][NCH]) + ARW'(macc[2][NCH]);
    end
  end

  // ------------------------------------------ area path: square root chain
  logic [ARW-1:0] arad  [RA+1];
  logic [RA:0]    arem  [RA+1];
  logic [RA-1:0]  aroot [RA+1];

  assign arad[0]  = qsum_q;
  assign arem[0]  = '0;
  assign aroot[0] = '0;

  for (genvar i = 0; i < RA; i++) begin : g_asqrt
    tqm_sqrt_cell #(.N(ARW)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .rad_i (arad[i]),
      .rem_i (arem[i]),
      .root_i(aroot[i]),
      .rad_o (arad[i+1]),
      .rem_o (arem[i+1]),
      .root_o(aroot[i+1])
    );
  end

  // ------------------------------------------- edge path: length roots
  logic [SQW-1:0] erad  [3][RE+1];
  logic [RE:0]    erem  [3][RE+1];
  logic [RE-1:0]  eroot [3][RE+1];

  for (genvar j = 0; j < 3; j++) begin : g_esqrt
    assign erad[j][0]  = len2p_q[j];
    assign erem[j][0]  = '0;
    assign eroot[j][0] = '0;
    for (genvar i = 0; i < RE; i++) begin : g_cell
      tqm_sqrt_cell #(.N(SQW)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .rad_i (erad[j][i]),
        .rem_i (erem[j][i]),
        .root_i(eroot[j][i]),
        .rad_o (erad[j][i+1]),
        .rem_o (erem[j][i+1]),
        .root_o(eroot[j][i+1])
      );
    end
  end

  // a*b and the perimeter from the floored lengths
  logic [LABW-1:0] lab_q;
  logic [LW-1:0]   lc_q;
  logic [PRW-1:0]  perim_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lab_q   <= LABW'(eroot[0][RE]) * LABW'(eroot[1][RE]);
      lc_q    <= eroot[2][RE];
      perim_q <= PRW'(eroot[0][RE]) + PRW'(eroot[1][RE]) + PRW'(eroot[2][RE]);
    end
  end

  // a*b*c, one digit of c per cell
  logic [LABW-1:0] na   [NCHL+1];
  logic [LBP-1:0]  nb   [NCHL+1];
  logic [NUMW-1:0] nacc [NCHL+1];

  assign na[0]   = lab_q;
  assign nb[0]   = LBP'(lc_q);
  assign nacc[0] = '0;

  for (genvar i = 0; i < NCHL; i++) begin : g_num
    tqm_mul_cell #(
      .AW (LABW),
      .BPW(LBP),
      .PW (NUMW),
      .IDX(i)
    ) u_cell (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  (na[i]),
      .b_i  (nb[i]),
      .acc_i(nacc[i]),
      .a_o  (na[i+1]),
      .b_o  (nb[i+1]),
      .acc_o(nacc[i+1])
    );
  end

  // ------------------------------------- side data aligned to area result
  logic [PRW-1:0]  perim_m, perim_a;
  logic [NUMW-1:0] num_a;
  logic [SSW-1:0]  sumsq_a;
  logic            sh_a;

  tqm_delay #(.WIDTH(PRW), .DEPTH(NCHL)) u_dly_perim (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  (perim_q),
    .q_o  (perim_m)
  );

  tqm_delay #(.WIDTH(NUMW + PRW), .DEPTH(DE)) u_dly_edge (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({nacc[NCHL], perim_m}),
    .q_o  ({num_a, perim_a})
  );

  tqm_delay #(.WIDTH(SSW + 1), .DEPTH(DSUM)) u_dly_sum (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({sumsq5_q, sh_q}),
    .q_o  ({sumsq_a, sh_a})
  );

  // ------------------------------- twice the area, degenerate, threshold
  logic [TAW-1:0]  ta_d, ta_q;
  logic            degen_d, degen_q, below_d, below_q;
  logic [NUMW-1:0] num_f_q;
  logic [PRW-1:0]  perim_f_q;
  logic [SSW-1:0]  sumsq_f_q;

  always_comb begin
    ta_d    = sh_a ? (TAW'(aroot[RA]) << SHB) : TAW'(aroot[RA]);
    degen_d = (ta_d == '0);
    // threshold is in area units, compared against the doubled area exactly
    below_d = CMW'(ta_d) < (CMW'(thr_q) << (FRAC_BITS + 1));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ta_q      <= ta_d;
      degen_q   <= degen_d;
      below_q   <= below_d;
      num_f_q   <= num_a;
      perim_f_q <= perim_a;
      sumsq_f_q <= sumsq_a;
    end
  end

  // ------------------------------------- divider operands
  // outer = abc / (2 * 2A), inner = 2A / perimeter, shape = 2^17 sum / (3 * 2A)
  logic [ONW-1:0] on_q;
  logic [ODW-1:0] od_q;
  logic [INW-1:0] inn_q;
  logic [IDW-1:0] id_q;
  logic [SNW-1:0] sn_q;
  logic [SDW-1:0] sd_q;
  logic           degen_p_q, below_p_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      on_q      <= num_f_q;
      od_q      <= {ta_q, 1'b0};
      inn_q     <= ta_q;
      id_q      <= perim_f_q;
      sn_q      <= {sumsq_f_q, {tqm_pkg::SHAPE_SHIFT{1'b0}}};
      sd_q      <= SDW'(ta_q) + (SDW'(ta_q) << 1);
      degen_p_q <= degen_q;
      below_p_q <= below_q;
    end
  end

  // ------------------------- divider setup: overflow check, first remainder
  // a quotient that does not fit the result saturates, so only the low
  // quotient bits are ever worked out
  logic [ODW-1:0] o_d  [QW+1];
  logic [ODW-1:0] o_r  [QW+1];
  logic [QW-1:0]  o_nl [QW+1];
  logic [QW-1:0]  o_q  [QW+1];
  logic [IDW-1:0] i_d  [QW+1];
  logic [IDW-1:0] i_r  [QW+1];
  logic [QW-1:0]  i_nl [QW+1];
  logic [QW-1:0]  i_q  [QW+1];
  logic [SDW-1:0] s_d  [QW+1];
  logic [SDW-1:0] s_r  [QW+1];
  logic [QW-1:0]  s_nl [QW+1];
  logic [QW-1:0]  s_q  [QW+1];
  logic           ov_o_q, ov_i_q, ov_s_q, degen_s_q, below_s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ov_o_q    <= OXW'(on_q) >= (OXW'(od_q) << QW);
      ov_i_q    <= IXW'(inn_q) >= (IXW'(id_q) << QW);
      ov_s_q    <= SXW'(sn_q) >= (SXW'(sd_q) << QW);
      o_d[0]    <= od_q;
      o_r[0]    <= ODW'(on_q >> QW);
      o_nl[0]   <= QW'(on_q);
      i_d[0]    <= id_q;
      i_r[0]    <= IDW'(inn_q >> QW);
      i_nl[0]   <= QW'(inn_q);
      s_d[0]    <= sd_q;
      s_r[0]    <= SDW'(sn_q >> QW);
      s_nl[0]   <= QW'(sn_q);
      degen_s_q <= degen_p_q;
      below_s_q <= below_p_q;
    end
  end

  assign o_q[0] = '0;
  assign i_q[0] = '0;
  assign s_q[0] = '0;

  // ------------------------------------------------------- divider chains
  for (genvar i = 0; i < QW; i++) begin : g_div
    tqm_div_cell #(.DW(ODW)) u_outer (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (o_d[i]),
      .r_i   (o_r[i]),
      .nlow_i(o_nl[i]),
      .q_i   (o_q[i]),
      .d_o   (o_d[i+1]),
      .r_o   (o_r[i+1]),
      .nlow_o(o_nl[i+1]),
      .q_o   (o_q[i+1])
    );
    tqm_div_cell #(.DW(IDW)) u_inner (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (i_d[i]),
      .r_i   (i_r[i]),
      .nlow_i(i_nl[i]),
      .q_i   (i_q[i]),
      .d_o   (i_d[i+1]),
      .r_o   (i_r[i+1]),
      .nlow_o(i_nl[i+1]),
      .q_o   (i_q[i+1])
    );
    tqm_div_cell #(.DW(SDW)) u_shape (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (s_d[i]),
      .r_i   (s_r[i]),
      .nlow_i(s_nl[i]),
      .q_i   (s_q[i]),
      .d_o   (s_d[i+1]),
      .r_o   (s_r[i+1]),
      .nlow_o(s_nl[i+1]),
      .q_o   (s_q[i+1])
    );
  end

  // flags ride alongside the divider cells
  logic degen_e, below_e, ov_o_e, ov_i_e, ov_s_e;

  tqm_delay #(.WIDTH(FLW), .DEPTH(QW)) u_dly_flags (
    .clk_i(clk_i),
    .en_i (en),
    .d_i  ({degen_s_q, below_s_q, ov_o_q, ov_i_q, ov_s_q}),
    .q_o  ({degen_e, below_e, ov_o_e, ov_i_e, ov_s_e})
  );

  // ------------------------------------------------------ output register
  logic [OW-1:0] outer_q, inner_q, shape_q;
  logic          degen_o_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // degenerate: circumradius saturates, inradius is zero
      outer_q   <= (degen_e || ov_o_e) ? '1 : o_q[QW];
      inner_q   <= degen_e ? '0 : (ov_i_e ? '1 : i_q[QW]);
      // below threshold wins over everything for gamma
      shape_q   <= below_e ? '0 : ((degen_e || ov_s_e) ? '1 : s_q[QW]);
      degen_o_q <= degen_e;
    end
  end

  assign outer_radius_o = outer_q;
  assign inner_radius_o = inner_q;
  assign shape_ratio_o  = shape_q;
  assign degenerate_o   = degen_o_q;

endmodule
`default_nettype wire

// ===== sim/triangle_quality_metrics_checker.sv =====
// checker: predicts the metrics of each accepted triangle and compares results
`default_nettype none
module triangle_quality_metrics_checker #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [tqm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tqm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [COORD_WIDTH-1:0]     vertex_a_x_i,
  input  logic signed [COORD_WIDTH-1:0]     vertex_a_y_i,
  input  logic signed [COORD_WIDTH-1:0]     vertex_a_z_i,
  input  logic signed [COORD_WIDTH-1:0]     vertex_b_x_i,
  input  logic signed [COORD_WIDTH-1:0]     vertex_b_y_i,
  input  logic signed [COORD_WIDTH-1:0]     vertex_b_z_i,
  input  logic signed [COORD_WIDTH-1:0]     vertex_c_x_i,
  input  logic signed [COORD_WIDTH-1:0]     vertex_c_y_i,
  input  logic signed [COORD_WIDTH-1:0]     vertex_c_z_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [tqm_pkg::OUT_W-1:0]         outer_radius_i,
  input  logic [tqm_pkg::OUT_W-1:0]         inner_radius_i,
  input  logic [tqm_pkg::OUT_W-1:0]         shape_ratio_i,
  input  logic                              degenerate_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef bit [255:0] wide_t;
  typedef struct {
    bit [31:0] outer;
    bit [31:0] inner;
    bit [31:0] shape;
    bit        degen;
  } metrics_t;

  localparam wide_t SAT = 256'hFFFF_FFFF;

  logic [tqm_pkg::DIM_W-1:0] dim_mode;
  logic [31:0]               area_thr;
  metrics_t                  metrics_q[$];

  function automatic wide_t floor_sqrt(wide_t n);
    wide_t root, bitv;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      bitv = wide_t'(1) << (2 * i);
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
    end
    return root;
  endfunction

  function automatic wide_t mag(longint v);
    return v < 0 ? wide_t'(-v) : wide_t'(v);
  endfunction

  function automatic bit [31:0] sat32(wide_t x);
    return (x > SAT) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic wide_t sq_len(longint d[3]);
    return mag(d[0]) * mag(d[0]) + mag(d[1]) * mag(d[1]) + mag(d[2]) * mag(d[2]);
  endfunction

  function automatic metrics_t predict_metrics(longint p[3][3],
                                               logic [tqm_pkg::DIM_W-1:0] mode,
                                               logic [31:0] thr_reg);
    longint u[3], v[3], w[3];
    wide_t cr[3], a2, b2, c2, sumsq, la, lb, lc, perim, two_area, thr;
    int unsigned sh;
    bit below;
    metrics_t m;
    sh = 0;
    // 2d mode drops z entirely
    if (mode == tqm_pkg::DIM_2D) begin
      for (int i = 0; i < 3; i++) p[i][2] = 0;
    end
    for (int k = 0; k < 3; k++) begin
      u[k] = p[1][k] - p[0][k];
      v[k] = p[2][k] - p[0][k];
      w[k] = p[2][k] - p[1][k];
    end
    a2 = sq_len(u);
    b2 = sq_len(w);
    c2 = sq_len(v);
    sumsq = a2 + b2 + c2;
    la = floor_sqrt(a2);
    lb = floor_sqrt(b2);
    lc = floor_sqrt(c2);
    perim = la + lb + lc;
    cr[0] = mag(u[1] * v[2] - u[2] * v[1]);
    cr[1] = mag(u[2] * v[0] - u[0] * v[2]);
    cr[2] = mag(u[0] * v[1] - u[1] * v[0]);
    // prescale huge cross products
    for (int k = 0; k < 3; k++)
      if (cr[k] >= (wide_t'(1) << tqm_pkg::CROSS_LIM)) sh = tqm_pkg::CROSS_SHIFT;
    for (int k = 0; k < 3; k++) cr[k] = cr[k] >> sh;
    two_area = floor_sqrt(cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2]) << sh;
    thr = wide_t'(thr_reg) << (FRAC_BITS + 1);
    below = two_area < thr;
    if (two_area == 0) begin
      m.outer = 32'hFFFF_FFFF;
      m.inner = 0;
      m.shape = below ? 32'h0 : 32'hFFFF_FFFF;
      m.degen = 1'b1;
      return m;
    end
    m.outer = sat32((la * lb * lc) / (two_area << 1));
    m.inner = (perim == 0) ? 32'h0 : sat32(two_area / perim);
    m.shape = below ? 32'h0 :
              sat32((sumsq << tqm_pkg::SHAPE_SHIFT) / (two_area * 3));
    m.degen = 1'b0;
    return m;
  endfunction

  assign pending_o = metrics_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint   pts[3][3];
    metrics_t exp_m;
    if (!rst_ni) begin
      dim_mode = tqm_pkg::DIM_3D;
      area_thr = '0;
      metrics_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == tqm_pkg::REG_DIMENSION_MODE) dim_mode = cfg_data_i[1:0];
        else if (cfg_index_i == tqm_pkg::REG_AREA_THRESHOLD) area_thr = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        pts[0][0] = vertex_a_x_i; pts[0][1] = vertex_a_y_i; pts[0][2] = vertex_a_z_i;
        pts[1][0] = vertex_b_x_i; pts[1][1] = vertex_b_y_i; pts[1][2] = vertex_b_z_i;
        pts[2][0] = vertex_c_x_i; pts[2][1] = vertex_c_y_i; pts[2][2] = vertex_c_z_i;
        metrics_q.push_back(predict_metrics(pts, dim_mode, area_thr));
      end
      if (out_valid_i && out_ready_i) begin
        if (metrics_q.size() == 0) begin
          $error("result with no triangle pending");
          fail_count_o++;
        end else begin
          exp_m = metrics_q.pop_front();
          if (outer_radius_i !== exp_m.outer) begin
            $error("outer_radius expected %0h actual %0h", exp_m.outer, outer_radius_i);
            fail_count_o++;
          end
          if (inner_radius_i !== exp_m.inner) begin
            $error("inner_radius expected %0h actual %0h", exp_m.inner, inner_radius_i);
            fail_count_o++;
          end
          if (shape_ratio_i !== exp_m.shape) begin
            $error("shape_ratio expected %0h actual %0h", exp_m.shape, shape_ratio_i);
            fail_count_o++;
          end
          if (degenerate_i !== exp_m.degen) begin
            $error("degenerate expected %0b actual %0b", exp_m.degen, degenerate_i);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim/triangle_quality_metrics_tb.sv =====
// testbench top: triangle stimulus, config phases and verdict
`default_nettype none
module triangle_quality_metrics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = 24;
  localparam int          LATENCY = 97;
  localparam int          DRAIN_CYCLES = LATENCY + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tqm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tqm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] vtx [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [tqm_pkg::OUT_W-1:0] outer_radius, inner_radius, shape_ratio;
  logic degenerate;
  int   fail_count, pending;

  // shared control between stimulus and the result sink
  bit calm = 1'b0;       // no idling on either side
  bit hold_req = 1'b0;   // ask the sink for a long hold-off

  triangle_quality_metrics #(.COORD_WIDTH(CW), .FRAC_BITS(8)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .vertex_a_x_i(vtx[0]), .vertex_a_y_i(vtx[1]), .vertex_a_z_i(vtx[2]),
    .vertex_b_x_i(vtx[3]), .vertex_b_y_i(vtx[4]), .vertex_b_z_i(vtx[5]),
    .vertex_c_x_i(vtx[6]), .vertex_c_y_i(vtx[7]), .vertex_c_z_i(vtx[8]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .outer_radius_o(outer_radius), .inner_radius_o(inner_radius),
    .shape_ratio_o(shape_ratio), .degenerate_o(degenerate)
  );

  triangle_quality_metrics_checker #(.COORD_WIDTH(CW), .FRAC_BITS(8)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .vertex_a_x_i(vtx[0]), .vertex_a_y_i(vtx[1]), .vertex_a_z_i(vtx[2]),
    .vertex_b_x_i(vtx[3]), .vertex_b_y_i(vtx[4]), .vertex_b_z_i(vtx[5]),
    .vertex_c_x_i(vtx[6]), .vertex_c_y_i(vtx[7]), .vertex_c_z_i(vtx[8]),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .outer_radius_i(outer_radius), .inner_radius_i(inner_radius),
    .shape_ratio_i(shape_ratio), .degenerate_i(degenerate),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // result sink: random back-pressure, calm stretches, one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;   // longer than the pipeline depth, so the input stalls
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
      end
    end
  end

  // offer one triangle, idling at random first, and wait for acceptance
  task automatic send_triangle(input logic signed [CW-1:0] c[9]);
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) vtx[i] <= c[i];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [tqm_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for all results, then the pipeline depth, before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one coordinate: full range, mid scale, or a small value
  function automatic logic signed [CW-1:0] pick_coord(int scale);
    case (scale)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(65535)) - 32768);
      default: return CW'($signed($urandom_range(63)) - 32);
    endcase
  endfunction

  // random triangle: mostly proper, some collinear or repeated vertices
  task automatic random_triangle(output logic signed [CW-1:0] c[9]);
    int scale, kind, kmul;
    scale = $urandom_range(2);
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) c[i] = pick_coord(scale);
    if (kind == 0) begin
      // c = a + k*(b - a), small scale keeps it in range
      kmul = $signed($urandom_range(4)) - 2;
      for (int i = 0; i < 3; i++) begin
        c[i] = pick_coord(2);
        c[3 + i] = pick_coord(2);
        c[6 + i] = CW'(c[i] + kmul * (c[3 + i] - c[i]));
      end
    end else if (kind == 1) begin
      // repeated vertex
      for (int i = 0; i < 3; i++) c[3 + i] = c[i];
    end else if (kind == 2) begin
      // same in x and y, differs only in z
      for (int i = 0; i < 2; i++) begin
        c[3 + i] = c[i];
        c[6 + i] = c[i];
      end
    end
  endtask

  task automatic random_phase(input int count);
    logic signed [CW-1:0] c[9];
    for (int n = 0; n < count; n++) begin
      random_triangle(c);
      send_triangle(c);
    end
  endtask

  task automatic directed_item(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    logic signed [CW-1:0] c[9];
    c[0] = CW'(a0); c[1] = CW'(a1); c[2] = CW'(a2);
    c[3] = CW'(b0); c[4] = CW'(b1); c[5] = CW'(b2);
    c[6] = CW'(c0); c[7] = CW'(c1); c[8] = CW'(c2);
    send_triangle(c);
  endtask

  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset config: 3d, zero threshold
    directed_item(0, 0, 0, 0, 0, 0, 0, 0, 0);                     // all vertices equal
    directed_item(0, 0, 0, 256, 0, 0, 0, 256, 0);                 // unit right triangle
    directed_item(0, 0, 0, 1, 0, 0, 0, 1, 0);                     // smallest triangle
    directed_item(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, MINC); // extremes
    directed_item(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC);
    directed_item(MINC, 0, 0, MAXC, 0, 0, 0, 1, 0);               // huge, flat: saturates
    directed_item(0, 0, 0, 100, 100, 100, 200, 200, 200);         // collinear
    directed_item(5, 6, 7, 5, 6, 7, 9, 9, 9);                     // repeated vertex
    directed_item(0, 0, 0, 512, 0, 0, 256, 443, 0);               // near equilateral
    directed_item(0, 0, 0, 0, 0, 1000, 0, 0, -1000);              // collinear in z
    directed_item(-1, -1, -1, 1, 1, 1, -1, 1, 1);
    directed_item(MAXC, MAXC, 0, MAXC, 0, 0, 0, MAXC, 0);
    drain();

    // 2d mode: z ignored, z-only difference degenerates
    write_reg(tqm_pkg::REG_DIMENSION_MODE, 32'(tqm_pkg::DIM_2D));
    write_reg(tqm_pkg::REG_AREA_THRESHOLD, 32'hFFFF_FFFF);
    directed_item(0, 0, 5, 0, 0, 900, 0, 0, -7);                  // degenerate below threshold
    directed_item(0, 0, MAXC, 256, 0, MINC, 0, 256, 0);
    drain();
    write_reg(tqm_pkg::REG_AREA_THRESHOLD, 32'd1);
    directed_item(0, 0, 0, 1, 0, 0, 0, 1, 0);                     // tiny area below threshold
    directed_item(0, 0, 0, 64, 0, 0, 0, 16, 0);                   // area above threshold
    directed_item(0, 0, 0, 512, 0, 0, 0, 512, 0);
    drain();

    // random phases with a spread of settings
    write_reg(tqm_pkg::REG_DIMENSION_MODE, 32'(tqm_pkg::DIM_3D));
    write_reg(tqm_pkg::REG_AREA_THRESHOLD, 32'd0);
    random_phase(300);
    hold_req = 1'b1;     // long receiver hold-off while items keep coming
    random_phase(200);
    drain();

    write_reg(tqm_pkg::REG_DIMENSION_MODE, 32'(tqm_pkg::DIM_2D));
    write_reg(tqm_pkg::REG_AREA_THRESHOLD, $urandom_range(4095));
    random_phase(250);
    drain();

    write_reg(tqm_pkg::REG_DIMENSION_MODE, 32'hFFFF_FFFC);        // unused mode 0, as 3d
    write_reg(tqm_pkg::REG_AREA_THRESHOLD, $urandom);
    calm = 1'b1;         // stretch with no idling at all
    random_phase(250);
    calm = 1'b0;
    drain();

    write_reg(tqm_pkg::REG_DIMENSION_MODE, 32'd1);                // unused mode 1
    write_reg(tqm_pkg::REG_AREA_THRESHOLD, 32'hFFFF_FFFF);
    random_phase(200);
    drain();

    write_reg(tqm_pkg::REG_DIMENSION_MODE, 32'(tqm_pkg::DIM_3D));
    write_reg(tqm_pkg::REG_AREA_THRESHOLD, $urandom_range(255));
    random_phase(300);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
